@@ rtl/bezier_subdivide_2d_assert.svh @@
// Assertion macros shared by the RTL of the Bezier subdivision block.
// Expects signals named clock and reset in the scope of each use.
`ifndef BEZIER_SUBDIVIDE_2D_ASSERT_SVH
`define BEZIER_SUBDIVIDE_2D_ASSERT_SVH

// same-cycle implication
`define BZS_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BZS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bzs_pkg.sv @@
// Shared constants, register indexes and the controller-to-datapath command
// struct for the Bezier subdivision block. No dependencies.
`default_nettype none

package bzs_pkg;

   localparam int DEG_W          = 4;
   localparam int T_W            = 17;
   localparam int COORD_W        = 32;
   localparam int MAX_DEGREE_DEF = 15;

   localparam logic [T_W-1:0]   T_ONE     = 17'h10000;
   localparam logic [T_W-1:0]   T_RESET   = 17'h08000;
   localparam logic [DEG_W-1:0] DEG_RESET = 4'd3;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = T_W;
   localparam logic [CSR_IDX_W-1:0] CFG_DEGREE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CFG_SPLIT_T = 1'b1;

   // stream widths
   localparam int REQ_W      = 2 * COORD_W;
   localparam int RSP_FLDS_W = DEG_W + 4 * COORD_W;
   localparam int RSP_W      = ((RSP_FLDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_W - RSP_FLDS_W;

   typedef struct packed {
      logic ld_en;     // write incoming point into the point store
      logic ld_first;  // incoming point is index 0: also seeds left[0]
      logic cap_t;     // final point: capture the split parameter
      logic lerp;      // read this cycle feeds the lerp pipeline
      logic rd_prime;  // lerp read of index 0 only loads the carry register
      logic out_load;  // load the result register from the read data
      logic out_last;  // result being loaded is the last of the run
   } bzs_cmd_type;

endpackage

`default_nettype wire

@@ rtl/bzs_ctrl.sv @@
// Controller: configuration registers, load counter and the sequencer that
// walks the de Casteljau passes and result readout. Uses bzs_pkg.
`default_nettype none

module bzs_ctrl
   import bzs_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF,
   localparam int AW = $clog2(MAX_DEGREE + 1),
   localparam int IW = (AW > DEG_W) ? AW : DEG_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output bzs_cmd_type                cmd,
   output logic [AW-1:0]              ld_addr,
   output logic [AW-1:0]              rd_addr,
   output logic [AW-1:0]              pass_idx,
   output logic [DEG_W-1:0]           out_index,
   output logic [T_W-1:0]             split_t
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_GAP,
      ST_DRAIN,
      ST_ORD,
      ST_OLD,
      ST_OWAIT
   } state_type;

   state_type         state_ff;
   logic [DEG_W-1:0]  degree_ff;
   logic [T_W-1:0]    split_t_ff;
   logic [IW-1:0]     count_ff;
   logic [IW-1:0]     deg_ff;
   logic [IW-1:0]     pass_ff;
   logic [IW-1:0]     rptr_ff;
   logic [IW-1:0]     oidx_ff;
   logic              drain_ff;
   logic              rsp_tvalid_ff;

   logic [IW-1:0]     deg_cur;
   logic [IW-1:0]     idx;
   logic [IW-1:0]     last_rd;
   logic              accept;
   logic              final_pt;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff  <= DEG_RESET;
         split_t_ff <= T_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CFG_DEGREE:  degree_ff  <= csr_wdata[DEG_W-1:0];
            CFG_SPLIT_T: split_t_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign deg_cur  = (IW'(degree_ff) > IW'(MAX_DEGREE)) ? IW'(MAX_DEGREE) : IW'(degree_ff);
   assign idx      = (count_ff > deg_cur) ? deg_cur : count_ff;
   assign accept   = req_tvalid && (state_ff == ST_LOAD);
   assign final_pt = (idx >= deg_cur);
   // pass p updates indexes 0..deg-p, reading one ahead
   assign last_rd  = deg_ff - pass_ff + IW'(1);

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign split_t    = split_t_ff;

   always_comb begin
      cmd          = '0;
      cmd.ld_en    = accept;
      cmd.ld_first = accept && (idx == '0);
      cmd.cap_t    = accept && final_pt;
      cmd.lerp     = (state_ff == ST_PASS);
      cmd.rd_prime = (state_ff == ST_PASS) && (rptr_ff == '0);
      cmd.out_load = (state_ff == ST_OLD);
      cmd.out_last = (oidx_ff == deg_ff);
   end

   assign ld_addr   = idx[AW-1:0];
   assign rd_addr   = (state_ff == ST_PASS) ? rptr_ff[AW-1:0] : oidx_ff[AW-1:0];
   assign pass_idx  = pass_ff[AW-1:0];
   assign out_index = DEG_W'(oidx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         deg_ff        <= '0;
         pass_ff       <= '0;
         rptr_ff       <= '0;
         oidx_ff       <= '0;
         drain_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (final_pt) begin
                     count_ff <= '0;
                     deg_ff   <= deg_cur;
                     pass_ff  <= IW'(1);
                     rptr_ff  <= '0;
                     oidx_ff  <= '0;
                     drain_ff <= 1'b0;
                     state_ff <= (deg_cur == '0) ? ST_DRAIN : ST_PASS;
                  end else begin
                     count_ff <= idx + IW'(1);
                  end
               end
            end
            ST_PASS: begin
               if (rptr_ff == last_rd) begin
                  rptr_ff <= '0;
                  if (pass_ff == deg_ff) begin
                     drain_ff <= 1'b0;
                     state_ff <= ST_DRAIN;
                  end else begin
                     pass_ff  <= pass_ff + IW'(1);
                     state_ff <= ST_GAP;
                  end
               end else begin
                  rptr_ff <= rptr_ff + IW'(1);
               end
            end
            // lets the write of index 1 land before the next pass reads it
            ST_GAP: state_ff <= ST_PASS;
            ST_DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff) state_ff <= ST_ORD;
            end
            ST_ORD: state_ff <= ST_OLD;
            ST_OLD: begin
               rsp_tvalid_ff <= 1'b1;
               state_ff      <= ST_OWAIT;
            end
            ST_OWAIT: begin
               if (rsp_tready) begin
                  rsp_tvalid_ff <= 1'b0;
                  if (oidx_ff == deg_ff) begin
                     oidx_ff  <= '0;
                     state_ff <= ST_LOAD;
                  end else begin
                     oidx_ff  <= oidx_ff + IW'(1);
                     state_ff <= ST_ORD;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/bzs_dp.sv @@
// Datapath: point store, left-point buffer, x/y lerp pipeline (read, multiply,
// add/write back) and the result register. Driven by bzs_ctrl; uses bzs_pkg.
`default_nettype none

module bzs_dp
   import bzs_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF,
   localparam int DEPTH = MAX_DEGREE + 1,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bzs_cmd_type               cmd,
   input  wire logic [AW-1:0]             ld_addr,
   input  wire logic [AW-1:0]             rd_addr,
   input  wire logic [AW-1:0]             pass_idx,
   input  wire logic [DEG_W-1:0]          out_index,
   input  wire logic [T_W-1:0]            split_t,
   input  wire logic signed [COORD_W-1:0] point_x,
   input  wire logic signed [COORD_W-1:0] point_y,
   output logic [DEG_W-1:0]               rsp_index,
   output logic signed [COORD_W-1:0]      left_x,
   output logic signed [COORD_W-1:0]      left_y,
   output logic signed [COORD_W-1:0]      right_x,
   output logic signed [COORD_W-1:0]      right_y,
   output logic                           last_of_run
);

   // entries are {y, x}; after the passes the point store holds the right curve
   logic [2*COORD_W-1:0] st_mem [DEPTH];
   logic [2*COORD_W-1:0] lb_mem [DEPTH];
   logic [2*COORD_W-1:0] st_rd_ff;
   logic [2*COORD_W-1:0] lb_rd_ff;

   logic [T_W-1:0]             t_ff;
   logic                       m_vld_ff;
   logic                       m_prime_ff;
   logic [AW-1:0]              m_addr_ff;
   logic [AW-1:0]              m_pass_ff;
   logic signed [COORD_W-1:0]  a_x_ff;
   logic signed [COORD_W-1:0]  a_y_ff;
   logic signed [COORD_W-1:0]  a2_x_ff;
   logic signed [COORD_W-1:0]  a2_y_ff;
   logic signed [COORD_W-1:0]  prod_x_ff;
   logic signed [COORD_W-1:0]  prod_y_ff;
   logic                       w_vld_ff;
   logic                       w_first_ff;
   logic [AW-1:0]              w_addr_ff;
   logic [AW-1:0]              w_pass_ff;

   logic [DEG_W-1:0]           rsp_index_ff;
   logic signed [COORD_W-1:0]  left_x_ff;
   logic signed [COORD_W-1:0]  left_y_ff;
   logic signed [COORD_W-1:0]  right_x_ff;
   logic signed [COORD_W-1:0]  right_y_ff;
   logic                       last_ff;

   logic signed [COORD_W-1:0]  rd_x;
   logic signed [COORD_W-1:0]  rd_y;
   logic signed [COORD_W:0]    diff_x;
   logic signed [COORD_W:0]    diff_y;
   logic signed [T_W:0]        t_s;
   logic signed [COORD_W+T_W+1:0] mul_x;
   logic signed [COORD_W+T_W+1:0] mul_y;
   logic signed [COORD_W-1:0]  res_x;
   logic signed [COORD_W-1:0]  res_y;

   assign rd_x   = st_rd_ff[COORD_W-1:0];
   assign rd_y   = st_rd_ff[2*COORD_W-1:COORD_W];
   assign diff_x = {rd_x[COORD_W-1], rd_x} - {a_x_ff[COORD_W-1], a_x_ff};
   assign diff_y = {rd_y[COORD_W-1], rd_y} - {a_y_ff[COORD_W-1], a_y_ff};
   assign t_s    = {1'b0, t_ff};
   assign mul_x  = diff_x * t_s;
   assign mul_y  = diff_y * t_s;
   // bits 47:16 are the floored shift modulo 2^32; the sum stays in the hull
   assign res_x  = a2_x_ff + prod_x_ff;
   assign res_y  = a2_y_ff + prod_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.ld_en) begin
         st_mem[ld_addr] <= {point_y, point_x};
      end else if (w_vld_ff) begin
         st_mem[w_addr_ff] <= {res_y, res_x};
      end
      st_rd_ff <= st_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_first) begin
         lb_mem[{AW{1'b0}}] <= {point_y, point_x};
      end else if (w_vld_ff && w_first_ff) begin
         lb_mem[w_pass_ff] <= {res_y, res_x};
      end
      lb_rd_ff <= lb_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         w_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= cmd.lerp;
         w_vld_ff <= m_vld_ff && !m_prime_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_t) t_ff <= (split_t > T_ONE) ? T_ONE : split_t;
      m_prime_ff <= cmd.rd_prime;
      m_addr_ff  <= rd_addr;
      m_pass_ff  <= pass_idx;
      if (m_vld_ff) begin
         // the point read now is the b of this step and the a of the next
         a_x_ff <= rd_x;
         a_y_ff <= rd_y;
      end
      a2_x_ff    <= a_x_ff;
      a2_y_ff    <= a_y_ff;
      prod_x_ff  <= mul_x[COORD_W+15:16];
      prod_y_ff  <= mul_y[COORD_W+15:16];
      w_addr_ff  <= m_addr_ff - AW'(1);
      w_first_ff <= (m_addr_ff == AW'(1));
      w_pass_ff  <= m_pass_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_index_ff <= out_index;
         left_x_ff    <= lb_rd_ff[COORD_W-1:0];
         left_y_ff    <= lb_rd_ff[2*COORD_W-1:COORD_W];
         right_x_ff   <= rd_x;
         right_y_ff   <= rd_y;
         last_ff      <= cmd.out_last;
      end
   end

   assign rsp_index   = rsp_index_ff;
   assign left_x      = left_x_ff;
   assign left_y      = left_y_ff;
   assign right_x     = right_x_ff;
   assign right_y     = right_y_ff;
   assign last_of_run = last_ff;

endmodule

`default_nettype wire

@@ rtl/bezier_subdivide_2d.sv @@
// Bezier subdivision (de Casteljau) top level. A point is accepted whenever
// req_tvalid is high in the load state. After the final point of a run the triangle
// is computed with one lerp per cycle within a pass on a shared x/y multiplier pair,
// one memory read port and an idle gap state between passes; then each result
// passes the read, load and wait states and waits on rsp_tready.
// Synchronous active-high reset; point store contents are left as they are.
`default_nettype none
`include "bezier_subdivide_2d_assert.svh"

module bezier_subdivide_2d
   import bzs_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_W-1:0]      req_tdata,   // point_x, point_y
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata,   // out_index, left_x, left_y,
                                                   // right_x, right_y, zero pad
   output logic                       rsp_tlast    // last_of_run
);

   localparam int AW = $clog2(MAX_DEGREE + 1);

   bzs_cmd_type               cmd;
   logic [AW-1:0]             ld_addr;
   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             pass_idx;
   logic [DEG_W-1:0]          out_index;
   logic [T_W-1:0]            split_t;
   logic [DEG_W-1:0]          rsp_index;
   logic signed [COORD_W-1:0] left_x;
   logic signed [COORD_W-1:0] left_y;
   logic signed [COORD_W-1:0] right_x;
   logic signed [COORD_W-1:0] right_y;

   bzs_ctrl #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .ld_addr    (ld_addr),
      .rd_addr    (rd_addr),
      .pass_idx   (pass_idx),
      .out_index  (out_index),
      .split_t    (split_t)
   );

   bzs_dp #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .ld_addr     (ld_addr),
      .rd_addr     (rd_addr),
      .pass_idx    (pass_idx),
      .out_index   (out_index),
      .split_t     (split_t),
      .point_x     (req_tdata[COORD_W-1:0]),
      .point_y     (req_tdata[2*COORD_W-1:COORD_W]),
      .rsp_index   (rsp_index),
      .left_x      (left_x),
      .left_y      (left_y),
      .right_x     (right_x),
      .right_y     (right_y),
      .last_of_run (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, right_y, right_x, left_y, left_x, rsp_index};

   `BZS_ASSERT_IMPL(a_no_load_while_out, rsp_tvalid, !req_tready, "load open during readout")
   `BZS_ASSERT_NEXT(a_one_result_per_rd, rsp_tvalid && rsp_tready, !rsp_tvalid, "result repeated")
   `BZS_ASSERT_NEXT(a_last_reopens_load, rsp_tvalid && rsp_tready && rsp_tlast, req_tready, "load not reopened after last result")

endmodule

`default_nettype wire
